/* src/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/crc24c_pkg.sv */
// Package of the CRC-24 bit flip corrector: frame and CRC constants, CRC step
// functions and the per-bit syndrome table. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package crc24c_pkg;

  localparam int unsigned FrameBits  = 112;
  localparam int unsigned HalfBits   = 56;
  localparam int unsigned FrameBytes = 14;
  localparam int unsigned CrcW       = 24;
  localparam int unsigned MaskW      = 8;
  localparam int unsigned PosW       = 7;
  localparam int unsigned CountW     = 4;
  localparam int unsigned PosTabSize = 128;

  // Generator 0x1FFF409 without its top term.
  localparam logic [CrcW-1:0] CrcPoly = 24'hFFF409;

  typedef logic [PosTabSize-1:0][CrcW-1:0] syn_tab_t;

  function automatic logic [CrcW-1:0] crc_bit(logic [CrcW-1:0] crc, logic din);
    logic fb;
    fb = crc[CrcW-1] ^ din;
    crc_bit = {crc[CrcW-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
  endfunction

  function automatic logic [CrcW-1:0] crc_byte(logic [CrcW-1:0] crc, logic [7:0] din);
    logic [CrcW-1:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      c = crc_bit(c, din[7-k]);
    end
    crc_byte = c;
  endfunction

  // Remainder of a frame that has only the given bit set. Positions past the
  // end of the frame contribute nothing.
  function automatic syn_tab_t build_syn_tab();
    syn_tab_t t;
    logic [CrcW-1:0] cur;
    t = '0;
    cur = CrcPoly;
    for (int p = FrameBits - 1; p >= 0; p--) begin
      t[PosW'(p)] = cur;
      cur = crc_bit(cur, 1'b0);
    end
    build_syn_tab = t;
  endfunction

  localparam syn_tab_t SynTab = build_syn_tab();

endpackage

`default_nettype wire

/* src/crc24c_syndrome_unit.sv */
// Shared check unit: combines the frame remainder with the syndromes of the
// suspects selected by the current mask and flags a zero result. Uses crc24c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crc24c_syndrome_unit
  import crc24c_pkg::*;
#(
  parameter int unsigned NumSus = 8
) (
  input  logic [CrcW-1:0]   base_crc_i,
  input  logic [CrcW-1:0]   syn_i [NumSus],
  input  logic [NumSus-1:0] mask_i,
  output logic              hit_o
);

  logic [CrcW-1:0] rem;

  always_comb begin
    rem = base_crc_i;
    for (int k = 0; k < NumSus; k++) begin
      if (mask_i[k]) begin
        rem = rem ^ syn_i[k];
      end
    end
  end

  assign hit_o = (rem == '0);

endmodule

`default_nettype wire

/* src/crc24c_flip_unit.sv */
// Applies the bit flips of the chosen suspects to the stored frame.
// Uses crc24c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crc24c_flip_unit
  import crc24c_pkg::*;
#(
  parameter int unsigned NumSus = 8
) (
  input  logic [FrameBits-1:0] frame_i,
  input  logic [PosW-1:0]      pos_i [NumSus],
  input  logic [NumSus-1:0]    mask_i,
  output logic [FrameBits-1:0] data_o
);

  logic [PosW-1:0] idx;

  always_comb begin
    data_o = frame_i;
    idx = '0;
    for (int k = 0; k < NumSus; k++) begin
      idx = PosW'(FrameBits - 1) - pos_i[k];
      if (mask_i[k] && (pos_i[k] < PosW'(FrameBits))) begin
        data_o[idx] = ~data_o[idx];
      end
    end
  end

endmodule

`default_nettype wire

/* src/crc24_bit_flip_corrector.sv */
// Top level of the CRC-24 bit flip corrector with its sequencer.
// Uses crc24c_pkg, crc24c_syndrome_unit and crc24c_flip_unit.
//
// An accepted frame first has its CRC-24 remainder computed one byte per
// cycle in the StCrc state. The shared check unit then tests one suspect
// subset per cycle in increasing mask order, adding the registered syndrome
// of each chosen suspect to that remainder, until a zero remainder is seen
// or all 2^n - 1 subsets are spent, at most 255; with no suspect given the
// search is skipped. The StWrite state then writes the result register. The
// input is not ready while a frame is being worked on, so the next request
// is taken only after the result is written. A result waiting in the output
// register does not stop the next frame from being taken, but that frame
// cannot write its result until the waiting one has been taken.
`timescale 1ns / 1ps
`default_nettype none

module crc24_bit_flip_corrector
  import crc24c_pkg::*;
#(
  parameter int unsigned MAX_SUSPECTS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [HalfBits-1:0]  frame_high_i,
  input  logic [HalfBits-1:0]  frame_low_i,
  input  logic [CountW-1:0]    suspect_count_i,
  input  logic [PosW-1:0]      suspect_pos_0_i,
  input  logic [PosW-1:0]      suspect_pos_1_i,
  input  logic [PosW-1:0]      suspect_pos_2_i,
  input  logic [PosW-1:0]      suspect_pos_3_i,
  input  logic [PosW-1:0]      suspect_pos_4_i,
  input  logic [PosW-1:0]      suspect_pos_5_i,
  input  logic [PosW-1:0]      suspect_pos_6_i,
  input  logic [PosW-1:0]      suspect_pos_7_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 found_o,
  output logic [MaskW-1:0]     flip_mask_o,
  output logic [HalfBits-1:0]  data_high_o,
  output logic [HalfBits-1:0]  data_low_o
);

  localparam int unsigned NumSus = MAX_SUSPECTS;
  localparam int unsigned ByteW  = $clog2(FrameBytes);

  typedef enum logic [1:0] {
    StIdle,
    StCrc,
    StSearch,
    StWrite
  } state_e;

  state_e              state_q;
  logic [FrameBits-1:0] frame_q;
  logic [PosW-1:0]     pos_q [NumSus];
  logic [CrcW-1:0]     syn_q [NumSus];
  logic [NumSus-1:0]   lim_q;
  logic [NumSus-1:0]   mask_q;
  logic [NumSus-1:0]   res_mask_q;
  logic                res_found_q;
  logic [CrcW-1:0]     crc_q;
  logic [ByteW-1:0]    byte_cnt_q;
  logic                out_valid_q;
  logic                found_q;
  logic [MaskW-1:0]    flip_mask_q;
  logic [FrameBits-1:0] data_q;

  logic [PosW-1:0]     pos_in [MaskW];
  logic [NumSus-1:0]   lim_in;
  logic [PosW-1:0]     byte_top;
  logic [7:0]          cur_byte;
  logic                hit;
  logic [FrameBits-1:0] flipped;
  logic                in_fire;

  assign pos_in[0] = suspect_pos_0_i;
  assign pos_in[1] = suspect_pos_1_i;
  assign pos_in[2] = suspect_pos_2_i;
  assign pos_in[3] = suspect_pos_3_i;
  assign pos_in[4] = suspect_pos_4_i;
  assign pos_in[5] = suspect_pos_5_i;
  assign pos_in[6] = suspect_pos_6_i;
  assign pos_in[7] = suspect_pos_7_i;

  always_comb begin
    for (int k = 0; k < NumSus; k++) begin
      lim_in[k] = (suspect_count_i > CountW'(k));
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  assign byte_top = PosW'(FrameBits - 1) - PosW'({byte_cnt_q, 3'b000});
  assign cur_byte = frame_q[byte_top -: 8];

  crc24c_syndrome_unit #(
    .NumSus(NumSus)
  ) u_syndrome (
    .base_crc_i(crc_q),
    .syn_i     (syn_q),
    .mask_i    (mask_q),
    .hit_o     (hit)
  );

  crc24c_flip_unit #(
    .NumSus(NumSus)
  ) u_flip (
    .frame_i(frame_q),
    .pos_i  (pos_q),
    .mask_i (res_mask_q),
    .data_o (flipped)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      frame_q     <= '0;
      lim_q       <= '0;
      mask_q      <= '0;
      res_mask_q  <= '0;
      res_found_q <= 1'b0;
      crc_q       <= '0;
      byte_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      flip_mask_q <= '0;
      data_q      <= '0;
      for (int k = 0; k < NumSus; k++) begin
        pos_q[k] <= '0;
        syn_q[k] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i && (state_q != StWrite)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            frame_q     <= {frame_high_i, frame_low_i};
            lim_q       <= lim_in;
            mask_q      <= NumSus'(1);
            res_mask_q  <= '0;
            res_found_q <= 1'b0;
            crc_q       <= '0;
            byte_cnt_q  <= '0;
            for (int k = 0; k < NumSus; k++) begin
              pos_q[k] <= pos_in[k];
              syn_q[k] <= SynTab[pos_in[k]];
            end
            state_q <= StCrc;
          end
        end
        StCrc: begin
          crc_q      <= crc_byte(crc_q, cur_byte);
          byte_cnt_q <= byte_cnt_q + 1'b1;
          if (byte_cnt_q == ByteW'(FrameBytes - 1)) begin
            state_q <= (lim_q == '0) ? StWrite : StSearch;
          end
        end
        StSearch: begin
          if (hit) begin
            res_found_q <= 1'b1;
            res_mask_q  <= mask_q;
            state_q     <= StWrite;
          end else if (mask_q == lim_q) begin
            state_q <= StWrite;
          end else begin
            mask_q <= mask_q + 1'b1;
          end
        end
        StWrite: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            found_q     <= res_found_q;
            flip_mask_q <= MaskW'(res_mask_q);
            data_q      <= flipped;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign flip_mask_o = flip_mask_q;
  assign data_high_o = data_q[FrameBits-1:HalfBits];
  assign data_low_o  = data_q[HalfBits-1:0];

endmodule

`default_nettype wire

/* src/crc24c_checker.sv */
// Port-level checker for the CRC-24 bit flip corrector and its bind.
// Uses crc24c_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module crc24c_checker
  import crc24c_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_o,
  input  logic             out_valid_o,
  input  logic             out_ready_i,
  input  logic             found_o,
  input  logic [MaskW-1:0] flip_mask_o
);

  // A result that is not taken stays offered.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  // A failed search reports an empty mask.
  `ASSERT_SAME(a_miss_mask, clk_i, rst_ni, out_valid_o && !found_o, flip_mask_o == '0)
  // A successful search always names at least one flipped suspect.
  `ASSERT_SAME(a_hit_mask, clk_i, rst_ni, out_valid_o && found_o, flip_mask_o != '0)
  // The block is busy in the cycle after it takes a request.
  `ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind crc24_bit_flip_corrector crc24c_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .found_o    (found_o),
  .flip_mask_o(flip_mask_o)
);

`default_nettype wire
